/* rtl/core/mgrt_pkg.sv */
// ----------------------------------------------------------------------------
// Min-gap reservation table package
// Shared sizes, codes and types for the reservation cell row and its
// count tree.
// ----------------------------------------------------------------------------
package mgrt_pkg;

	// Table size and field widths.
	localparam int CAPACITY   = 64;
	localparam int TIME_BITS  = 20;
	localparam int GAP_BITS   = 8;
	localparam int COUNT_W    = $clog2(CAPACITY + 1);

	// Reset value of the minimum gap register.
	localparam logic [GAP_BITS-1:0] GAP_RESET = GAP_BITS'(3);

	// The count tree sums the cell flags in groups of this size.
	localparam int GROUP_SIZE = 8;
	localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GROUP_W    = $clog2(GROUP_SIZE + 1);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CONFLICT = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// Request kinds.
	typedef enum logic {
		KIND_RESERVE = 1'b0,
		KIND_COUNT   = 1'b1
	} kind_t;

	// Sequencer phases of one transaction.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMP,
		PH_SUM,
		PH_DONE
	} phase_t;

	// Query broadcast to every cell.
	typedef struct packed {
		logic [TIME_BITS-1:0] time_value;
		logic [GAP_BITS-1:0]  min_gap;
	} query_t;

	// Per-cell compare results.
	typedef struct packed {
		logic conflict;
		logic at_or_before;
	} cell_flags_t;

endpackage

/* rtl/core/mgrt_cell.sv */
// ----------------------------------------------------------------------------
// Reservation cell
// Holds one reserved time, passes it to the next cell on an insert, and
// compares it against the broadcast query.
// ----------------------------------------------------------------------------
module mgrt_cell (
	input  logic                              clk,
	input  logic                              shift_en,
	input  logic [mgrt_pkg::TIME_BITS-1:0]    shift_in,
	output logic [mgrt_pkg::TIME_BITS-1:0]    shift_out,
	input  logic                              active,
	input  mgrt_pkg::query_t                  query,
	output mgrt_pkg::cell_flags_t             flags_s1
);

	logic [mgrt_pkg::TIME_BITS-1:0] time_q;
	logic [mgrt_pkg::TIME_BITS-1:0] diff;
	logic                           conflict;
	logic                           at_or_before;

	// Stored time moves one cell down the row on every insert.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			time_q <= shift_in;
		end
	end

	assign shift_out = time_q;

	// Distance to the query time and the two compare results.
	always_comb begin
		if (time_q >= query.time_value) begin
			diff = time_q - query.time_value;
		end else begin
			diff = query.time_value - time_q;
		end
		conflict = active && ((diff == '0) ||
			(diff < mgrt_pkg::TIME_BITS'(query.min_gap)));
		at_or_before = active && (time_q <= query.time_value);
	end

	// Registered flags feed the count tree.
	always_ff @(posedge clk) begin
		flags_s1.conflict     <= conflict;
		flags_s1.at_or_before <= at_or_before;
	end

endmodule

/* rtl/core/mgrt_count.sv */
// ----------------------------------------------------------------------------
// Reservation count tree
// Sums the at-or-before flags and merges the conflict flags of all cells
// through one registered group level.
// ----------------------------------------------------------------------------
module mgrt_count (
	input  logic                             clk,
	input  mgrt_pkg::cell_flags_t            flags [mgrt_pkg::CAPACITY],
	output logic [mgrt_pkg::COUNT_W-1:0]     total,
	output logic                             conflict_any
);

	logic [mgrt_pkg::GROUP_W-1:0] grp_cnt    [mgrt_pkg::NUM_GROUPS];
	logic                         grp_conf   [mgrt_pkg::NUM_GROUPS];
	logic [mgrt_pkg::GROUP_W-1:0] grp_cnt_s2 [mgrt_pkg::NUM_GROUPS];
	logic                         grp_conf_s2[mgrt_pkg::NUM_GROUPS];

	// First level: one small popcount and OR per group of cells.
	always_comb begin
		for (int g = 0; g < mgrt_pkg::NUM_GROUPS; g++) begin
			grp_cnt[g]  = '0;
			grp_conf[g] = 1'b0;
			for (int k = 0; k < mgrt_pkg::GROUP_SIZE; k++) begin
				if (g * mgrt_pkg::GROUP_SIZE + k < mgrt_pkg::CAPACITY) begin
					grp_cnt[g] = grp_cnt[g] + mgrt_pkg::GROUP_W'(
						flags[g * mgrt_pkg::GROUP_SIZE + k].at_or_before);
					grp_conf[g] = grp_conf[g] ||
						flags[g * mgrt_pkg::GROUP_SIZE + k].conflict;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < mgrt_pkg::NUM_GROUPS; g++) begin
			grp_cnt_s2[g]  <= grp_cnt[g];
			grp_conf_s2[g] <= grp_conf[g];
		end
	end

	// Second level: add the group counts and merge the group conflicts.
	always_comb begin
		total        = '0;
		conflict_any = 1'b0;
		for (int g = 0; g < mgrt_pkg::NUM_GROUPS; g++) begin
			total        = total + mgrt_pkg::COUNT_W'(grp_cnt_s2[g]);
			conflict_any = conflict_any || grp_conf_s2[g];
		end
	end

endmodule

/* rtl/core/min_gap_reservation_table_top.sv */
// ----------------------------------------------------------------------------
// Min-gap reservation table
// Stores up to CAPACITY reserved times in a row of cells. A reserve request
// is refused when a stored time lies closer than min_gap; a count request
// returns how many stored times lie at or before the query time.
//
//   Channel   Signals                          Handshake
//   request   kind, time_value                 start high while busy low
//   result    status, planes_count             done strobe, one cycle
//   config    cfg_wdata (min_gap)              cfg_we, no wait
//
// A transaction passes in order through the compare in the cells, the group
// sums of the count tree and the final sum and decision, and the done strobe
// is registered after that. busy drops in the cycle of the done strobe, so a
// new request can be taken then, but not before the last one is done.
// The result cannot be held off, so nothing stalls once a request is taken.
// Reset clears the occupancy count and sets min_gap to 3; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module min_gap_reservation_table_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [mgrt_pkg::TIME_BITS-1:0]    time_value,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [mgrt_pkg::COUNT_W-1:0]      planes_count,
	input  logic                              cfg_we,
	input  logic [mgrt_pkg::GAP_BITS-1:0]     cfg_wdata
);

	mgrt_pkg::phase_t                phase_q;
	mgrt_pkg::phase_t                phase_next;
	logic                            accept;
	logic                            finish;
	logic                            is_full;
	logic                            insert;

	logic [mgrt_pkg::GAP_BITS-1:0]   min_gap_q;
	logic [mgrt_pkg::COUNT_W-1:0]    occ_q;
	mgrt_pkg::kind_t                 kind_q;
	logic [mgrt_pkg::TIME_BITS-1:0]  query_time_q;
	mgrt_pkg::query_t                query;

	logic [mgrt_pkg::TIME_BITS-1:0]  cell_time [mgrt_pkg::CAPACITY];
	mgrt_pkg::cell_flags_t           cell_flags [mgrt_pkg::CAPACITY];
	logic [mgrt_pkg::COUNT_W-1:0]    total;
	logic                            conflict_any;

	logic                            done_q;
	mgrt_pkg::status_t               status_q;
	logic [mgrt_pkg::COUNT_W-1:0]    planes_count_q;

	assign accept = start && !busy;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= mgrt_pkg::GAP_RESET;
		end else if (cfg_we) begin
			min_gap_q <= cfg_wdata;
		end
	end

	// Request capture; held for the whole transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= mgrt_pkg::kind_t'(kind);
			query_time_q <= time_value;
		end
	end

	assign query.time_value = query_time_q;
	assign query.min_gap    = min_gap_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mgrt_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_next;
		end
	end

	// Sequencer next state.
	always_comb begin
		unique case (phase_q)
			mgrt_pkg::PH_IDLE: phase_next = accept ? mgrt_pkg::PH_CMP : mgrt_pkg::PH_IDLE;
			mgrt_pkg::PH_CMP:  phase_next = mgrt_pkg::PH_SUM;
			mgrt_pkg::PH_SUM:  phase_next = mgrt_pkg::PH_DONE;
			mgrt_pkg::PH_DONE: phase_next = mgrt_pkg::PH_IDLE;
			default:           phase_next = mgrt_pkg::PH_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy   = (phase_q != mgrt_pkg::PH_IDLE);
		finish = (phase_q == mgrt_pkg::PH_DONE);
	end

	// Insert decision at the end of a reserve transaction.
	assign is_full = (occ_q == mgrt_pkg::COUNT_W'(mgrt_pkg::CAPACITY));
	assign insert  = finish && (kind_q == mgrt_pkg::KIND_RESERVE) &&
		!conflict_any && !is_full;

	// Occupancy count; cells below it hold valid times.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (insert) begin
			occ_q <= occ_q + 1'b1;
		end
	end

	// Row of cells; a new time enters at the head and the row shifts down.
	for (genvar i = 0; i < mgrt_pkg::CAPACITY; i++) begin : g_cell
		logic [mgrt_pkg::TIME_BITS-1:0] shift_in;
		logic                           active;

		if (i == 0) begin : g_head
			assign shift_in = query_time_q;
		end else begin : g_body
			assign shift_in = cell_time[i-1];
		end

		assign active = (mgrt_pkg::COUNT_W'(i) < occ_q);

		mgrt_cell u_cell (
			.clk       (clk),
			.shift_en  (insert),
			.shift_in  (shift_in),
			.shift_out (cell_time[i]),
			.active    (active),
			.query     (query),
			.flags_s1  (cell_flags[i])
		);
	end

	// Count and conflict reduction over the row.
	mgrt_count u_count (
		.clk          (clk),
		.flags        (cell_flags),
		.total        (total),
		.conflict_any (conflict_any)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (finish) begin
			priority if (kind_q == mgrt_pkg::KIND_COUNT) begin
				status_q       <= mgrt_pkg::ST_OK;
				planes_count_q <= total;
			end else if (conflict_any) begin
				status_q       <= mgrt_pkg::ST_CONFLICT;
				planes_count_q <= '0;
			end else if (is_full) begin
				status_q       <= mgrt_pkg::ST_FULL;
				planes_count_q <= '0;
			end else begin
				status_q       <= mgrt_pkg::ST_OK;
				planes_count_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign planes_count = planes_count_q;

`ifndef SYNTHESIS
	// An accepted request keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not make the block busy");

	// The occupancy count never passes the number of cells.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= mgrt_pkg::COUNT_W'(mgrt_pkg::CAPACITY))
		else $error("occupancy count beyond capacity");

	// A full status is only reported while every cell is in use.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == mgrt_pkg::ST_FULL) |-> is_full)
		else $error("full status reported with free cells");

	// A nonzero count only comes with an answered status.
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && planes_count_q != '0) |-> (status_q == mgrt_pkg::ST_OK))
		else $error("nonzero count with a refusal status");

	// The occupancy only grows at the end of a transaction.
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> done_q)
		else $error("occupancy changed outside a transaction end");
`endif

endmodule

/* sim/min_gap_reservation_table_top_test.sv */
// ----------------------------------------------------------------------------
// Min-gap reservation table testbench
// Drives reserve and count requests through the start/busy port and checks
// every done strobe against a mirror of the reservation table. The run steps
// through several minimum gap settings, the extremes among them, and fills
// the table so that the full status and its ordering behind the conflict
// test are both exercised.
// ----------------------------------------------------------------------------
module min_gap_reservation_table_top_test;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int RANDOM_ITEMS  = 185;
	localparam int TIME_MAX      = (1 << mgrt_pkg::TIME_BITS) - 1;

	// One expected result of a transaction.
	typedef struct {
		mgrt_pkg::status_t                status;
		logic [mgrt_pkg::COUNT_W-1:0]     planes;
	} answer_t;

	// Mirror of the table: it holds its own copy of the stored times and the
	// gap register and queues the answer of every accepted transaction.
	class reservation_mirror;
		logic [mgrt_pkg::TIME_BITS-1:0] slot [mgrt_pkg::CAPACITY];
		int                             occupancy;
		logic [mgrt_pkg::GAP_BITS-1:0]  gap;
		answer_t                        pending_answers[$];
		int                             errors;

		function new();
			occupancy = 0;
			gap = mgrt_pkg::GAP_RESET;
			errors = 0;
		endfunction

		function void set_gap(logic [mgrt_pkg::GAP_BITS-1:0] value);
			gap = value;
		endfunction

		// Work out the answer of one request and update the table.
		function answer_t predict_answer(mgrt_pkg::kind_t req,
				logic [mgrt_pkg::TIME_BITS-1:0] t);
			answer_t                        a;
			logic [mgrt_pkg::TIME_BITS-1:0] gap_dist;
			bit                             clash;
			a.status = mgrt_pkg::ST_OK;
			a.planes = '0;
			clash = 0;
			if (req == mgrt_pkg::KIND_COUNT) begin
				for (int i = 0; i < occupancy; i++)
					if (slot[i] <= t)
						a.planes = a.planes + 1'b1;
			end else begin
				for (int i = 0; i < occupancy; i++) begin
					gap_dist = (slot[i] >= t) ? slot[i] - t : t - slot[i];
					// An equal time conflicts even when the gap is zero.
					if (gap_dist == '0 || gap_dist < mgrt_pkg::TIME_BITS'(gap))
						clash = 1;
				end
				if (clash)
					a.status = mgrt_pkg::ST_CONFLICT;
				else if (occupancy >= mgrt_pkg::CAPACITY)
					a.status = mgrt_pkg::ST_FULL;
				else begin
					slot[occupancy] = t;
					occupancy++;
				end
			end
			return a;
		endfunction

		function void take_request(mgrt_pkg::kind_t req,
				logic [mgrt_pkg::TIME_BITS-1:0] t);
			pending_answers.push_back(predict_answer(req, t));
		endfunction

		function void match_result(logic [1:0] st, logic [mgrt_pkg::COUNT_W-1:0] n);
			answer_t a;
			if (pending_answers.size() == 0) begin
				$error("unexpected result: status %0d, planes_count %0d", st, n);
				errors++;
			end else begin
				a = pending_answers.pop_front();
				if (st !== a.status) begin
					$error("status: expected %0d, got %0d", a.status, st);
					errors++;
				end
				if (n !== a.planes) begin
					$error("planes_count: expected %0d, got %0d", a.planes, n);
					errors++;
				end
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic                                kind;
	logic [mgrt_pkg::TIME_BITS-1:0]      time_value;
	logic                                done;
	logic [1:0]                          status;
	logic [mgrt_pkg::COUNT_W-1:0]        planes_count;
	logic                                cfg_we;
	logic [mgrt_pkg::GAP_BITS-1:0]       cfg_wdata;

	reservation_mirror mirror = new();
	int cycle_count = 0;

	min_gap_reservation_table_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.time_value   (time_value),
		.done         (done),
		.status       (status),
		.planes_count (planes_count),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch the ports: results first, since a new transaction can be taken
	// in the cycle of the done strobe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.match_result(status, planes_count);
			if (start && !busy)
				mirror.take_request(mgrt_pkg::kind_t'(kind), time_value);
			if (cfg_we)
				mirror.set_gap(cfg_wdata);
		end
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one transaction after an idle stretch and hold it until taken.
	// start stays high afterwards so that back-to-back requests need no gap.
	task automatic send_request(mgrt_pkg::kind_t req,
			logic [mgrt_pkg::TIME_BITS-1:0] t);
		int idle;
		idle = $urandom_range(0, 4);
		if (idle > 0) begin
			start <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		start <= 1'b1;
		kind <= req;
		time_value <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Let every outstanding transaction finish before touching the register.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (mirror.pending_answers.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_gap(logic [mgrt_pkg::GAP_BITS-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random request. Most reserves land near a stored time so that the
	// gap boundary is hit from both sides; counts probe around stored times, at the end points and at random.
	task automatic random_request();
		int                             pick;
		int                             g;
		int                             v;
		logic [mgrt_pkg::TIME_BITS-1:0] t;
		mgrt_pkg::kind_t                req;
		pick = $urandom_range(0, 99);
		g = mirror.gap;
		if (pick < 35 && mirror.occupancy > 0) begin
			v = mirror.slot[$urandom_range(0, mirror.occupancy - 1)];
			v = v + $urandom_range(0, 2 * g + 2) - (g + 1);
			req = mgrt_pkg::KIND_RESERVE;
		end else if (pick < 55) begin
			v = $urandom_range(0, TIME_MAX);
			req = mgrt_pkg::KIND_RESERVE;
		end else if (pick < 75 && mirror.occupancy > 0) begin
			v = mirror.slot[$urandom_range(0, mirror.occupancy - 1)];
			v = v + $urandom_range(0, 2) - 1;
			req = mgrt_pkg::KIND_COUNT;
		end else if (pick < 82) begin
			v = $urandom_range(0, 1) ? TIME_MAX : 0;
			req = mgrt_pkg::KIND_COUNT;
		end else begin
			v = $urandom_range(0, TIME_MAX);
			req = mgrt_pkg::KIND_COUNT;
		end
		if (v < 0)
			v = 0;
		if (v > TIME_MAX)
			v = TIME_MAX;
		t = v[mgrt_pkg::TIME_BITS-1:0];
		send_request(req, t);
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = 1'b0;
		time_value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gap of three: empty counts, end points, equal and near times.
		send_request(mgrt_pkg::KIND_COUNT, '0);
		send_request(mgrt_pkg::KIND_COUNT, '1);
		send_request(mgrt_pkg::KIND_RESERVE, '0);
		send_request(mgrt_pkg::KIND_RESERVE, '1);
		send_request(mgrt_pkg::KIND_RESERVE, '0);
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(2));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(3));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(TIME_MAX - 2));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(TIME_MAX - 3));
		send_request(mgrt_pkg::KIND_COUNT, '0);
		send_request(mgrt_pkg::KIND_COUNT, mgrt_pkg::TIME_BITS'(2));
		send_request(mgrt_pkg::KIND_COUNT, mgrt_pkg::TIME_BITS'(3));
		send_request(mgrt_pkg::KIND_COUNT, mgrt_pkg::TIME_BITS'(TIME_MAX - 1));
		send_request(mgrt_pkg::KIND_COUNT, '1);

		// A gap of zero: only an equal time conflicts.
		write_gap(8'd0);
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(100));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(101));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(100));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'(99));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'('h55555));
		send_request(mgrt_pkg::KIND_RESERVE, mgrt_pkg::TIME_BITS'('hAAAAA));
		send_request(mgrt_pkg::KIND_COUNT, mgrt_pkg::TIME_BITS'(101));

		// Random phases over the widest gap, a gap of one and two middle gaps.
		// The table fills along the way, after which reserves are refused
		// as full unless they conflict.
		write_gap(8'd255);
		repeat (RANDOM_ITEMS) random_request();
		write_gap(8'd1);
		repeat (RANDOM_ITEMS) random_request();
		write_gap(mgrt_pkg::GAP_BITS'($urandom_range(2, 254)));
		repeat (RANDOM_ITEMS) random_request();
		write_gap(mgrt_pkg::GAP_BITS'($urandom_range(2, 254)));
		repeat (RANDOM_ITEMS) random_request();

		wait_drained();
		if (mirror.pending_answers.size() != 0)
			$error("%0d results never arrived", mirror.pending_answers.size());
		if (mirror.errors == 0 && mirror.pending_answers.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
